### src/lzd_pkg.sv
`timescale 1ns / 1ps

package lzd_pkg;

    localparam int OUT_BYTES = 8;
    localparam int COUNT_W   = 4;
    localparam int TOTAL_W   = 32;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_COPY,
        ST_REJECT
    } lzd_state_t;

    typedef struct packed {
        logic [OUT_BYTES-1:0][7:0] bytes;
        logic [COUNT_W-1:0]        count;
        logic                      last;
        logic                      error;
        logic [TOTAL_W-1:0]        total;
    } lzd_chunk_t;

endpackage

### src/lzd_ram.sv
`timescale 1ns / 1ps

module lzd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### src/lzd_chunk_out.sv
`timescale 1ns / 1ps

module lzd_chunk_out (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               load,
    input  lzd_pkg::lzd_chunk_t                chunk,
    output logic                               free,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [lzd_pkg::OUT_BYTES-1:0][7:0] bytes,
    output logic [lzd_pkg::COUNT_W-1:0]        count,
    output logic                               last,
    output logic                               error,
    output logic [lzd_pkg::TOTAL_W-1:0]        total
);

    logic                valid_reg;
    lzd_pkg::lzd_chunk_t chunk_reg;

    assign free = !valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (free)
        begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (free && load)
        begin
            chunk_reg <= chunk;
        end
    end

    assign out_valid = valid_reg;
    assign bytes     = chunk_reg.bytes;
    assign count     = chunk_reg.count;
    assign last      = chunk_reg.last;
    assign error     = chunk_reg.error;
    assign total     = chunk_reg.total;

endmodule

### src/lz77_triple_decoder.sv
`timescale 1ns / 1ps

// LZ77 token decoder over a sliding history held in one synchronous RAM.
// Input channel: one token per beat (match_offset, match_length,
// literal_symbol, last_triple), valid/stall handshake. in_stall is low only
// while the decoder is idle, so one token is worked on at a time.
// Output channel: chunks of up to BYTES_PER_RESULT bytes in out_byte_0..7,
// byte_count, chunk_last on the final chunk of a token, decode_error and the
// running decoded_total. A rejected token gives one beat with decode_error.
// Without receiver stalls the copy moves one byte per cycle through the
// history RAM (read, write back, forwarding for overlapping copies), pausing
// at each chunk for the last read to land and for the handoff to the output
// register. Each token is accepted in the idle state, and a new token is taken
// only after the last chunk of the previous one has been handed off.
// While out_stall is high the last chunk is held and the next chunk waits in
// the assembly buffer; the copy pauses when that buffer fills and no bytes are lost.
// Reset clears the stream counters and error state; the history RAM is not
// cleared, since offsets are checked against the bytes decoded so far.
module lz77_triple_decoder #(
    parameter int HISTORY_DEPTH    = 256,
    parameter int BYTES_PER_RESULT = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  match_offset,
    input  logic [7:0]  match_length,
    input  logic [7:0]  literal_symbol,
    input  logic        last_triple,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  out_byte_0,
    output logic [7:0]  out_byte_1,
    output logic [7:0]  out_byte_2,
    output logic [7:0]  out_byte_3,
    output logic [7:0]  out_byte_4,
    output logic [7:0]  out_byte_5,
    output logic [7:0]  out_byte_6,
    output logic [7:0]  out_byte_7,
    output logic [3:0]  byte_count,
    output logic        chunk_last,
    output logic        decode_error,
    output logic [31:0] decoded_total
);

    localparam int PTR_W  = $clog2(HISTORY_DEPTH);
    localparam int FILL_W = $clog2(BYTES_PER_RESULT + 1);
    localparam int IDX_W  = (BYTES_PER_RESULT > 1) ? $clog2(BYTES_PER_RESULT) : 1;
    localparam logic [PTR_W:0]    DEPTH_EXT = (PTR_W + 1)'(HISTORY_DEPTH);
    localparam logic [PTR_W-1:0]  PTR_LAST  = PTR_W'(HISTORY_DEPTH - 1);
    localparam logic [FILL_W:0]   BPR_EXT   = (FILL_W + 1)'(BYTES_PER_RESULT);
    localparam logic [FILL_W-1:0] BPR_FILL  = FILL_W'(BYTES_PER_RESULT);

    lzd_pkg::lzd_state_t state_reg, state_next;

    logic [PTR_W-1:0]  wp_reg, wp_next;
    logic [PTR_W-1:0]  ip_reg, ip_next;
    logic [31:0]       decoded_reg, decoded_next;
    logic              failed_reg, failed_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [7:0]        remain_reg, remain_next;
    logic              lit_pending_reg, lit_pending_next;
    logic              rd_valid_reg, rd_valid_next;
    logic              bypass_reg, bypass_next;
    logic              last_reg;
    logic [7:0]        offset_reg;
    logic [7:0]        symbol_reg;
    logic [7:0]        byp_data_reg;
    logic [7:0]        buf_reg [BYTES_PER_RESULT];

    logic              accept;
    logic              reject;
    logic [7:0]        ram_q;
    logic [7:0]        arrive_data;
    logic              can_issue;
    logic              lit_go;
    logic              write_en;
    logic [7:0]        wdata;
    logic [PTR_W-1:0]  src_addr;
    logic [PTR_W:0]    src_wrap;
    logic [PTR_W-1:0]  off_ext;
    logic              tok_done;
    logic              flush_go;
    logic              out_free;
    logic              chunk_load;
    logic [32:0]       total_sum;
    logic [31:0]       total_sat;

    logic [lzd_pkg::OUT_BYTES-1:0][7:0] chunk_bytes;
    lzd_pkg::lzd_chunk_t                chunk;
    logic [lzd_pkg::OUT_BYTES-1:0][7:0] out_bytes;

    assign in_stall = (state_reg != lzd_pkg::ST_IDLE);
    assign accept   = in_valid && !in_stall;
    assign reject   = failed_reg || ({24'd0, match_offset} > decoded_reg)
                   || (match_offset == 8'd0 && match_length != 8'd0);

    assign off_ext     = PTR_W'(offset_reg);
    assign src_wrap    = {1'b0, ip_reg} + DEPTH_EXT - {1'b0, off_ext};
    assign src_addr    = (ip_reg >= off_ext) ? (ip_reg - off_ext) : src_wrap[PTR_W-1:0];
    assign arrive_data = bypass_reg ? byp_data_reg : ram_q;

    assign total_sum = {1'b0, decoded_reg} + 33'(fill_reg);
    assign total_sat = total_sum[32] ? 32'hFFFF_FFFF : total_sum[31:0];

    genvar gi;
    generate
        for (gi = 0; gi < lzd_pkg::OUT_BYTES; gi++)
        begin : g_bytes
            if (gi < BYTES_PER_RESULT)
            begin : g_used
                assign chunk_bytes[gi] = (FILL_W'(gi) < fill_reg) ? buf_reg[gi] : 8'd0;
            end
            else
            begin : g_unused
                assign chunk_bytes[gi] = 8'd0;
            end
        end
    endgenerate

    always_comb
    begin
        state_next       = state_reg;
        wp_next          = wp_reg;
        ip_next          = ip_reg;
        decoded_next     = decoded_reg;
        failed_next      = failed_reg;
        fill_next        = fill_reg;
        remain_next      = remain_reg;
        lit_pending_next = lit_pending_reg;
        rd_valid_next    = 1'b0;
        bypass_next      = 1'b0;
        can_issue        = 1'b0;
        lit_go           = 1'b0;
        write_en         = 1'b0;
        wdata            = rd_valid_reg ? arrive_data : symbol_reg;
        tok_done         = 1'b0;
        flush_go         = 1'b0;
        chunk_load       = 1'b0;
        chunk            = '0;

        unique case (state_reg)
            lzd_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    remain_next      = match_length;
                    lit_pending_next = 1'b1;
                    ip_next          = wp_reg;
                    fill_next        = '0;
                    state_next       = reject ? lzd_pkg::ST_REJECT : lzd_pkg::ST_COPY;
                end
            end
            lzd_pkg::ST_COPY:
            begin
                can_issue = (remain_reg != 8'd0)
                         && (({1'b0, fill_reg} + (FILL_W + 1)'(rd_valid_reg)) < BPR_EXT);
                lit_go    = (remain_reg == 8'd0) && lit_pending_reg && !rd_valid_reg
                         && (fill_reg < BPR_FILL);
                write_en  = rd_valid_reg || lit_go;
                tok_done  = (remain_reg == 8'd0) && !lit_pending_reg && !rd_valid_reg;
                flush_go  = ((fill_reg == BPR_FILL) || (tok_done && fill_reg != '0))
                         && out_free;

                if (write_en)
                begin
                    wp_next   = (wp_reg == PTR_LAST) ? '0 : wp_reg + 1'b1;
                    fill_next = fill_reg + 1'b1;
                end
                if (lit_go)
                begin
                    lit_pending_next = 1'b0;
                end
                if (can_issue)
                begin
                    rd_valid_next = 1'b1;
                    bypass_next   = write_en && (src_addr == wp_reg);
                    remain_next   = remain_reg - 1'b1;
                    ip_next       = (ip_reg == PTR_LAST) ? '0 : ip_reg + 1'b1;
                end

                chunk.bytes = chunk_bytes;
                chunk.count = lzd_pkg::COUNT_W'(fill_reg);
                chunk.last  = tok_done;
                chunk.error = 1'b0;
                chunk.total = total_sat;

                if (flush_go)
                begin
                    chunk_load   = 1'b1;
                    fill_next    = '0;
                    decoded_next = total_sat;
                    if (tok_done)
                    begin
                        state_next = lzd_pkg::ST_IDLE;
                        if (last_reg)
                        begin
                            wp_next      = '0;
                            decoded_next = '0;
                            failed_next  = 1'b0;
                        end
                    end
                end
            end
            lzd_pkg::ST_REJECT:
            begin
                chunk.last  = 1'b1;
                chunk.error = 1'b1;
                chunk.total = decoded_reg;
                if (out_free)
                begin
                    chunk_load  = 1'b1;
                    failed_next = 1'b1;
                    state_next  = lzd_pkg::ST_IDLE;
                    if (last_reg)
                    begin
                        wp_next      = '0;
                        decoded_next = '0;
                        failed_next  = 1'b0;
                    end
                end
            end
            default:
            begin
                state_next = lzd_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lzd_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg          <= '0;
            ip_reg          <= '0;
            decoded_reg     <= '0;
            failed_reg      <= 1'b0;
            fill_reg        <= '0;
            remain_reg      <= '0;
            lit_pending_reg <= 1'b0;
            rd_valid_reg    <= 1'b0;
            bypass_reg      <= 1'b0;
        end
        else
        begin
            wp_reg          <= wp_next;
            ip_reg          <= ip_next;
            decoded_reg     <= decoded_next;
            failed_reg      <= failed_next;
            fill_reg        <= fill_next;
            remain_reg      <= remain_next;
            lit_pending_reg <= lit_pending_next;
            rd_valid_reg    <= rd_valid_next;
            bypass_reg      <= bypass_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            offset_reg <= match_offset;
            symbol_reg <= literal_symbol;
            last_reg   <= last_triple;
        end
        byp_data_reg <= wdata;
        if (write_en)
        begin
            buf_reg[fill_reg[IDX_W-1:0]] <= wdata;
        end
    end

    lzd_ram #(
        .WIDTH (8),
        .DEPTH (HISTORY_DEPTH)
    ) u_history (
        .clk   (clk),
        .we    (write_en),
        .waddr (wp_reg),
        .wdata (wdata),
        .raddr (src_addr),
        .rdata (ram_q)
    );

    lzd_chunk_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (chunk_load),
        .chunk     (chunk),
        .free      (out_free),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .bytes     (out_bytes),
        .count     (byte_count),
        .last      (chunk_last),
        .error     (decode_error),
        .total     (decoded_total)
    );

    assign out_byte_0 = out_bytes[0];
    assign out_byte_1 = out_bytes[1];
    assign out_byte_2 = out_bytes[2];
    assign out_byte_3 = out_bytes[3];
    assign out_byte_4 = out_bytes[4];
    assign out_byte_5 = out_bytes[5];
    assign out_byte_6 = out_bytes[6];
    assign out_byte_7 = out_bytes[7];

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps

module testbench;

    localparam int CYCLE_LIMIT   = 600000;
    localparam int RANDOM_TOKENS = 150;
    localparam int HOLD_CYCLES   = 400;
    localparam int DRAIN_CYCLES  = 40;

    typedef enum int {
        RX_FLOW,
        RX_LIGHT,
        RX_HALF,
        RX_HEAVY
    } rx_mode_t;

    class decoded_chunk_board_t;
        logic [7:0]          history [256];
        logic [7:0]          wr_ptr;
        logic [31:0]         decoded;
        logic                failed;
        lzd_pkg::lzd_chunk_t pending_chunks [$];
        int                  errors;
        int                  tokens;
        int                  rejected;
        int                  streams;
        int                  chunks_seen;

        function new();
            wr_ptr      = '0;
            decoded     = '0;
            failed      = 1'b0;
            errors      = 0;
            tokens      = 0;
            rejected    = 0;
            streams     = 0;
            chunks_seen = 0;
        endfunction

        function int pending_count();
            return pending_chunks.size();
        endfunction

        function void note_token(logic [7:0] off, logic [7:0] len, logic [7:0] sym,
                                 logic last);
            logic [7:0]          run_bytes [256];
            lzd_pkg::lzd_chunk_t c;
            int                  total;
            int                  pos;
            int                  n;
            int                  i;
            tokens++;
            if (failed || off > decoded || (off == 0 && len != 0))
            begin
                failed  = 1'b1;
                rejected++;
                c       = '0;
                c.last  = 1'b1;
                c.error = 1'b1;
                c.total = decoded;
                pending_chunks.push_back(c);
            end
            else
            begin
                for (i = 0; i < len; i++)
                begin
                    run_bytes[i]    = history[8'(wr_ptr - off)];
                    history[wr_ptr] = run_bytes[i];
                    wr_ptr++;
                end
                history[wr_ptr] = sym;
                wr_ptr++;
                run_bytes[len] = sym;
                total = len + 1;
                pos   = 0;
                while (pos < total)
                begin
                    n = (total - pos > lzd_pkg::OUT_BYTES) ? lzd_pkg::OUT_BYTES
                                                           : total - pos;
                    c = '0;
                    for (i = 0; i < n; i++)
                        c.bytes[i] = run_bytes[pos + i];
                    c.count = n[lzd_pkg::COUNT_W-1:0];
                    pos += n;
                    if (decoded > 32'hFFFF_FFFF - 32'(n))
                        decoded = 32'hFFFF_FFFF;
                    else
                        decoded = decoded + 32'(n);
                    c.last  = (pos >= total);
                    c.total = decoded;
                    pending_chunks.push_back(c);
                end
            end
            if (last)
            begin
                streams++;
                wr_ptr  = '0;
                decoded = '0;
                failed  = 1'b0;
            end
        endfunction

        function void check_chunk(lzd_pkg::lzd_chunk_t got);
            lzd_pkg::lzd_chunk_t want;
            int                  i;
            chunks_seen++;
            if (pending_chunks.size() == 0)
            begin
                $error("unexpected chunk: byte_count %0d decoded_total %0d",
                       got.count, got.total);
                errors++;
                return;
            end
            want = pending_chunks.pop_front();
            for (i = 0; i < lzd_pkg::OUT_BYTES; i++)
                if (got.bytes[i] !== want.bytes[i])
                begin
                    $error("out_byte_%0d expected %0d actual %0d", i, want.bytes[i],
                           got.bytes[i]);
                    errors++;
                end
            if (got.count !== want.count)
            begin
                $error("byte_count expected %0d actual %0d", want.count, got.count);
                errors++;
            end
            if (got.last !== want.last)
            begin
                $error("chunk_last expected %0d actual %0d", want.last, got.last);
                errors++;
            end
            if (got.error !== want.error)
            begin
                $error("decode_error expected %0d actual %0d", want.error, got.error);
                errors++;
            end
            if (got.total !== want.total)
            begin
                $error("decoded_total expected %0d actual %0d", want.total, got.total);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  match_offset;
    logic [7:0]  match_length;
    logic [7:0]  literal_symbol;
    logic        last_triple;
    logic        out_valid;
    logic        out_stall;
    logic [7:0]  out_byte_0;
    logic [7:0]  out_byte_1;
    logic [7:0]  out_byte_2;
    logic [7:0]  out_byte_3;
    logic [7:0]  out_byte_4;
    logic [7:0]  out_byte_5;
    logic [7:0]  out_byte_6;
    logic [7:0]  out_byte_7;
    logic [3:0]  byte_count;
    logic        chunk_last;
    logic        decode_error;
    logic [31:0] decoded_total;

    decoded_chunk_board_t board;
    int                   cycle_count;
    int                   burst_left;
    int                   stream_bytes;
    bit                   stream_bad;
    bit                   hold_req;

    lz77_triple_decoder DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .match_offset   (match_offset),
        .match_length   (match_length),
        .literal_symbol (literal_symbol),
        .last_triple    (last_triple),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .out_byte_0     (out_byte_0),
        .out_byte_1     (out_byte_1),
        .out_byte_2     (out_byte_2),
        .out_byte_3     (out_byte_3),
        .out_byte_4     (out_byte_4),
        .out_byte_5     (out_byte_5),
        .out_byte_6     (out_byte_6),
        .out_byte_7     (out_byte_7),
        .byte_count     (byte_count),
        .chunk_last     (chunk_last),
        .decode_error   (decode_error),
        .decoded_total  (decoded_total)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    always @(posedge clk)
    begin
        lzd_pkg::lzd_chunk_t got;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                board.note_token(match_offset, match_length, literal_symbol, last_triple);
            if (out_valid && !out_stall)
            begin
                got.bytes = {out_byte_7, out_byte_6, out_byte_5, out_byte_4,
                             out_byte_3, out_byte_2, out_byte_1, out_byte_0};
                got.count = byte_count;
                got.last  = chunk_last;
                got.error = decode_error;
                got.total = decoded_total;
                board.check_chunk(got);
            end
        end
    end

    // receiver: own stall pattern, plus one long hold-off on request
    initial
    begin
        rx_mode_t mode;
        int       run_left;
        int       hold_left;
        mode      = RX_FLOW;
        run_left  = 0;
        hold_left = 0;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (run_left == 0)
            begin
                mode     = rx_mode_t'($urandom_range(0, 3));
                run_left = $urandom_range(10, 80);
            end
            run_left--;
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                case (mode)
                    RX_FLOW:  out_stall <= 1'b0;
                    RX_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
                    RX_HALF:  out_stall <= 1'($urandom_range(0, 1));
                    default:  out_stall <= ($urandom_range(0, 9) != 0);
                endcase
            end
        end
    end

    task automatic send_token(input logic [7:0] off, input logic [7:0] len,
                              input logic [7:0] sym, input logic last);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                @(negedge clk);
                in_valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(1, 6);
        end
        burst_left--;
        @(negedge clk);
        in_valid       <= 1'b1;
        match_offset   <= off;
        match_length   <= len;
        literal_symbol <= sym;
        last_triple    <= last;
        do @(posedge clk); while (in_stall);
        if (stream_bad || off > stream_bytes || (off == 0 && len != 0))
            stream_bad = 1'b1;
        else
            stream_bytes += len + 1;
        if (last)
        begin
            stream_bytes = 0;
            stream_bad   = 1'b0;
        end
    endtask

    task automatic drain_results();
        @(negedge clk);
        in_valid <= 1'b0;
        burst_left = 0;
        while (board.pending_count() != 0)
            @(posedge clk);
    endtask

    task automatic send_random_token();
        logic [7:0] off;
        logic [7:0] len;
        logic       last;
        int         r;
        int         reach;
        r     = $urandom_range(0, 99);
        reach = (stream_bytes > 255) ? 255 : stream_bytes;
        if (r < 8)
        begin
            off = 8'($urandom_range(0, 255));
            len = 8'($urandom_range(0, 255));
        end
        else if (r < 13)
        begin
            if (reach < 255)
            begin
                off = 8'($urandom_range(reach + 1, 255));
                len = 8'($urandom_range(0, 31));
            end
            else
            begin
                off = '0;
                len = 8'($urandom_range(1, 255));
            end
        end
        else
        begin
            r = $urandom_range(0, 9);
            if (r < 7)
                len = 8'($urandom_range(0, 15));
            else if (r < 9)
                len = 8'($urandom_range(16, 63));
            else
                len = 8'($urandom_range(64, 255));
            if (reach == 0 || $urandom_range(0, 15) == 0)
            begin
                off = '0;
                len = '0;
            end
            else
                off = 8'($urandom_range(1, reach));
        end
        last = stream_bad ? ($urandom_range(0, 1) == 1) : ($urandom_range(0, 15) == 0);
        send_token(off, len, 8'($urandom_range(0, 255)), last);
    endtask

    initial
    begin
        int n;
        board          = new();
        burst_left     = 0;
        stream_bytes   = 0;
        stream_bad     = 1'b0;
        hold_req       = 1'b0;
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        match_offset   = '0;
        match_length   = '0;
        literal_symbol = '0;
        last_triple    = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        send_token(8'd0,   8'd0,   8'h00, 1'b0);
        send_token(8'd1,   8'd7,   8'hFF, 1'b0);
        send_token(8'd0,   8'd0,   8'hA5, 1'b0);
        send_token(8'd3,   8'd12,  8'h5A, 1'b0);
        send_token(8'd10,  8'd255, 8'h81, 1'b0);
        send_token(8'd255, 8'd20,  8'h7E, 1'b0);
        send_token(8'd255, 8'd255, 8'h01, 1'b0);
        send_token(8'd200, 8'd8,   8'h02, 1'b0);
        send_token(8'd17,  8'd6,   8'hFE, 1'b0);
        send_token(8'd4,   8'd7,   8'h40, 1'b0);
        send_token(8'd0,   8'd5,   8'h11, 1'b0);
        send_token(8'd1,   8'd0,   8'h22, 1'b0);
        send_token(8'd0,   8'd0,   8'h33, 1'b1);
        send_token(8'd0,   8'd0,   8'h44, 1'b0);
        send_token(8'd2,   8'd3,   8'h55, 1'b0);
        send_token(8'd1,   8'd1,   8'h66, 1'b1);
        send_token(8'd0,   8'd0,   8'h77, 1'b1);
        send_token(8'd0,   8'd0,   8'h88, 1'b0);
        send_token(8'd1,   8'd15,  8'h99, 1'b0);
        send_token(8'd16,  8'd16,  8'hAA, 1'b1);
        send_token(8'd0,   8'd0,   8'hBB, 1'b0);
        send_token(8'd128, 8'd0,   8'hCC, 1'b0);
        send_token(8'd0,   8'd0,   8'hDD, 1'b1);
        drain_results();

        for (n = 0; n < RANDOM_TOKENS; n++)
        begin
            if (n == 60)
                hold_req = 1'b1;
            if (n == 120)
                drain_results();
            send_random_token();
        end
        drain_results();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d tokens in %0d streams, %0d of them rejected.",
                 board.tokens, board.streams, board.rejected);
        $display("Checked %0d output chunks in %0d cycles.", board.chunks_seen, cycle_count);
        if (board.errors == 0 && board.pending_count() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
